/* rtl/tpc_pkg.sv */
// Shared types and constants for the triangle plane clipper.
package tpc_pkg;

    localparam int COORD_W   = 32;              // Q16.16 coordinate
    localparam int NORM_W    = 18;              // Q2.16 normal component
    localparam int DIFF_W    = COORD_W + 1;     // coordinate difference
    localparam int PROD_W    = DIFF_W + NORM_W; // one distance term
    localparam int DIST_W    = PROD_W + 2;      // sum of three terms
    localparam int DEN_W     = DIST_W + 1;      // d(a) - d(b)
    localparam int FRAC_W    = 16;              // bits of t
    localparam int EDGE_LAT  = FRAC_W + 3;      // edge lane latency
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [NORM_W-1:0] NORM_Z_RST = NORM_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PT_X,
        REG_PT_Y,
        REG_PT_Z,
        REG_N_X,
        REG_N_Y,
        REG_N_Z
    } cfg_reg_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_c_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vtx_t;

    typedef struct packed {
        norm_c_t x;
        norm_c_t y;
        norm_c_t z;
    } norm_t;

    typedef struct packed {
        coord_t v0_x;
        coord_t v0_y;
        coord_t v0_z;
        coord_t v1_x;
        coord_t v1_y;
        coord_t v1_z;
        coord_t v2_x;
        coord_t v2_y;
        coord_t v2_z;
    } item_t;

    typedef struct packed {
        coord_t     out_v0_x;
        coord_t     out_v0_y;
        coord_t     out_v0_z;
        coord_t     out_v1_x;
        coord_t     out_v1_y;
        coord_t     out_v1_z;
        coord_t     out_v2_x;
        coord_t     out_v2_y;
        coord_t     out_v2_z;
        logic       last_tri;
        logic [1:0] tri_total;
    } result_t;

    // Triangle info carried alongside the edge lanes
    typedef struct packed {
        vtx_t       va;
        vtx_t       vb;
        vtx_t       vc;
        logic [1:0] n_in;
    } side_t;

endpackage

/* rtl/triangle_plane_clipper.sv */
// Top level: clips one triangle against a configured plane.
//
// Usage:
//  - Input: a triangle word on item is taken at a clock edge where start is
//    high and busy is low. busy rises for one cycle after each accepted word,
//    so no word is taken in that cycle; the output port, which delivers
//    up to two triangles per input, needs this gap.
//  - Output: each result word is on result for one cycle with result_valid
//    high; the receiver cannot stall. An input yields 0, 1 or 2 words; the
//    last one carries last_tri, and tri_total gives the count.
//  - Pipeline: three distance stages, a 19-stage edge lane (an entry stage,
//    16 division stages, one quotient bit each, then a multiply and an add
//    stage), and the output register. A second word, if any, follows the
//    first in the next cycle.
//  - Config: cfg_we/cfg_idx/cfg_data write one plane register per edge;
//    write only while no triangle is in flight.
//  - Reset: plane point (0,0,0), normal (0,0,1.0); pipeline emptied.
module triangle_plane_clipper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tpc_pkg::item_t                    item,
    input  logic                              cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [tpc_pkg::CFG_W-1:0]         cfg_data,
    output tpc_pkg::result_t                  result,
    output logic                              result_valid
);
    import tpc_pkg::*;

    vtx_t    pt_reg;
    norm_t   nrm_reg;
    logic    busy_reg;
    logic    accept;
    vtx_t    v_in [3];
    dist_t   vdist [3];
    vtx_t    vtx_reg [3][3];
    logic    valid_reg [3];
    side_t   side_reg [EDGE_LAT];
    logic    sv_reg [EDGE_LAT];
    side_t   side_next;
    logic [2:0] mask;
    logic [1:0] a_idx;
    logic [1:0] b_idx;
    logic [1:0] c_idx;
    vtx_t    l0_a, l0_b, l1_a, l1_b;
    dist_t   l0_da, l0_db, l1_da, l1_db;
    vtx_t    e0, e1;
    result_t first_w, second_w;
    result_t res_reg, pend_reg;
    logic    res_valid_reg, pend_valid_reg;
    side_t   tail;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg  <= '0;
            nrm_reg <= '{x: '0, y: '0, z: NORM_Z_RST};
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_PT_X: pt_reg.x  <= coord_t'(cfg_data[COORD_W-1:0]);
                REG_PT_Y: pt_reg.y  <= coord_t'(cfg_data[COORD_W-1:0]);
                REG_PT_Z: pt_reg.z  <= coord_t'(cfg_data[COORD_W-1:0]);
                REG_N_X:  nrm_reg.x <= norm_c_t'(cfg_data[NORM_W-1:0]);
                REG_N_Y:  nrm_reg.y <= norm_c_t'(cfg_data[NORM_W-1:0]);
                REG_N_Z:  nrm_reg.z <= norm_c_t'(cfg_data[NORM_W-1:0]);
                default:  ;
            endcase
        end
    end

    // no word is taken while busy is high
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= accept;
    end

    assign v_in[0] = '{x: item.v0_x, y: item.v0_y, z: item.v0_z};
    assign v_in[1] = '{x: item.v1_x, y: item.v1_y, z: item.v1_z};
    assign v_in[2] = '{x: item.v2_x, y: item.v2_y, z: item.v2_z};

    // vertex lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_dist
        tpc_dist_lane u_dist (
            .clk   (clk),
            .p     (v_in[i]),
            .pt    (pt_reg),
            .nrm   (nrm_reg),
            .d_out (vdist[i])
        );
    end

    // vertices follow the distance stages
    always_ff @(posedge clk)
    begin
        vtx_reg[0] <= v_in;
        vtx_reg[1] <= vtx_reg[0];
        vtx_reg[2] <= vtx_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
            valid_reg[1] <= 1'b0;
            valid_reg[2] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            valid_reg[1] <= valid_reg[0];
            valid_reg[2] <= valid_reg[1];
        end
    end

    // classify: a, b, c in input order, inside ones first
    always_comb
    begin
        mask = {!vdist[2][DIST_W-1], !vdist[1][DIST_W-1], !vdist[0][DIST_W-1]};
        a_idx = 2'd0;
        b_idx = 2'd1;
        c_idx = 2'd2;
        side_next.n_in = 2'd0;
        unique case (mask)
            3'b001: begin a_idx = 2'd0; b_idx = 2'd1; c_idx = 2'd2; side_next.n_in = 2'd1; end
            3'b010: begin a_idx = 2'd1; b_idx = 2'd0; c_idx = 2'd2; side_next.n_in = 2'd1; end
            3'b100: begin a_idx = 2'd2; b_idx = 2'd0; c_idx = 2'd1; side_next.n_in = 2'd1; end
            3'b011: begin a_idx = 2'd0; b_idx = 2'd1; c_idx = 2'd2; side_next.n_in = 2'd2; end
            3'b101: begin a_idx = 2'd0; b_idx = 2'd2; c_idx = 2'd1; side_next.n_in = 2'd2; end
            3'b110: begin a_idx = 2'd1; b_idx = 2'd2; c_idx = 2'd0; side_next.n_in = 2'd2; end
            3'b111: side_next.n_in = 2'd3;
            default: side_next.n_in = 2'd0;
        endcase
        side_next.va = vtx_reg[2][a_idx];
        side_next.vb = vtx_reg[2][b_idx];
        side_next.vc = vtx_reg[2][c_idx];

        // one inside: edges a-b and a-c; two inside: a-c and b-c
        if (side_next.n_in == 2'd1)
        begin
            l0_a = side_next.va; l0_da = vdist[a_idx];
            l0_b = side_next.vb; l0_db = vdist[b_idx];
            l1_a = side_next.va; l1_da = vdist[a_idx];
        end
        else
        begin
            l0_a = side_next.va; l0_da = vdist[a_idx];
            l0_b = side_next.vc; l0_db = vdist[c_idx];
            l1_a = side_next.vb; l1_da = vdist[b_idx];
        end
        l1_b  = side_next.vc;
        l1_db = vdist[c_idx];
    end

    // edge lanes
    tpc_edge_lane u_edge0 (
        .clk (clk), .a (l0_a), .b (l0_b), .da (l0_da), .db (l0_db), .e (e0)
    );

    tpc_edge_lane u_edge1 (
        .clk (clk), .a (l1_a), .b (l1_b), .da (l1_da), .db (l1_db), .e (e1)
    );

    // triangle info waits for the edge lanes
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < EDGE_LAT; i++)
            side_reg[i] <= side_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EDGE_LAT; i++)
                sv_reg[i] <= 1'b0;
        end
        else
        begin
            sv_reg[0] <= valid_reg[2];
            for (int i = 1; i < EDGE_LAT; i++)
                sv_reg[i] <= sv_reg[i-1];
        end
    end

    // merge: build the one or two result words
    assign tail = side_reg[EDGE_LAT-1];

    always_comb
    begin
        first_w.out_v0_x = tail.va.x;
        first_w.out_v0_y = tail.va.y;
        first_w.out_v0_z = tail.va.z;
        if (tail.n_in == 2'd1)
        begin
            first_w.out_v1_x = e0.x; first_w.out_v1_y = e0.y; first_w.out_v1_z = e0.z;
            first_w.out_v2_x = e1.x; first_w.out_v2_y = e1.y; first_w.out_v2_z = e1.z;
        end
        else if (tail.n_in == 2'd2)
        begin
            first_w.out_v1_x = tail.vb.x; first_w.out_v1_y = tail.vb.y;
            first_w.out_v1_z = tail.vb.z;
            first_w.out_v2_x = e0.x; first_w.out_v2_y = e0.y; first_w.out_v2_z = e0.z;
        end
        else
        begin
            first_w.out_v1_x = tail.vb.x; first_w.out_v1_y = tail.vb.y;
            first_w.out_v1_z = tail.vb.z;
            first_w.out_v2_x = tail.vc.x; first_w.out_v2_y = tail.vc.y;
            first_w.out_v2_z = tail.vc.z;
        end
        first_w.last_tri  = (tail.n_in != 2'd2);
        first_w.tri_total = (tail.n_in == 2'd2) ? 2'd2 : 2'd1;

        second_w.out_v0_x = tail.vb.x; second_w.out_v0_y = tail.vb.y;
        second_w.out_v0_z = tail.vb.z;
        second_w.out_v1_x = e0.x; second_w.out_v1_y = e0.y; second_w.out_v1_z = e0.z;
        second_w.out_v2_x = e1.x; second_w.out_v2_y = e1.y; second_w.out_v2_z = e1.z;
        second_w.last_tri  = 1'b1;
        second_w.tri_total = 2'd2;
    end

    // output register and second-word hold
    always_ff @(posedge clk)
    begin
        if (sv_reg[EDGE_LAT-1])
        begin
            res_reg  <= first_w;
            pend_reg <= second_w;
        end
        else
            res_reg  <= pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (sv_reg[EDGE_LAT-1] && tail.n_in != 2'd0)
        begin
            res_valid_reg  <= 1'b1;
            pend_valid_reg <= (tail.n_in == 2'd2);
        end
        else
        begin
            res_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

`ifndef ASSERT_OFF
    // a pending second word never meets a new triangle at the merge
    a_no_merge_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !sv_reg[EDGE_LAT-1])
        else $error("new triangle at merge while second word pending");

    // first of two words is always followed by the last one
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_tri |=> result_valid && result.last_tri)
        else $error("second word of a pair missing");

    // single words are marked last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tri_total == 2'd1 |-> result.last_tri)
        else $error("single result not marked last");

    // busy only follows an accepted word
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without an accepted word");
`endif

endmodule

/* rtl/tpc_dist_lane.sv */
// One vertex lane: signed distance n.(p - pt), three register stages.
module tpc_dist_lane (
    input  logic           clk,
    input  tpc_pkg::vtx_t  p,
    input  tpc_pkg::vtx_t  pt,
    input  tpc_pkg::norm_t nrm,
    output tpc_pkg::dist_t d_out
);
    import tpc_pkg::*;

    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    dist_t                    dist_reg;
    logic signed [DIFF_W-1:0] diff_next [3];
    logic signed [NORM_W-1:0] nrm_a [3];

    // offset from the plane point
    always_comb
    begin
        diff_next[0] = DIFF_W'(p.x) - DIFF_W'(pt.x);
        diff_next[1] = DIFF_W'(p.y) - DIFF_W'(pt.y);
        diff_next[2] = DIFF_W'(p.z) - DIFF_W'(pt.z);
        nrm_a[0] = nrm.x;
        nrm_a[1] = nrm.y;
        nrm_a[2] = nrm.z;
    end

    // diff, product, sum
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_reg[k] <= diff_next[k];
            prod_reg[k] <= PROD_W'(diff_reg[k]) * PROD_W'(nrm_a[k]);
        end
        dist_reg <= DIST_W'(prod_reg[0]) + DIST_W'(prod_reg[1]) + DIST_W'(prod_reg[2]);
    end

    assign d_out = dist_reg;

endmodule

/* rtl/tpc_edge_lane.sv */
// One edge lane: t = d(a)/(d(a)-d(b)) one bit per stage, then a + (b-a)*t.
module tpc_edge_lane (
    input  logic           clk,
    input  tpc_pkg::vtx_t  a,
    input  tpc_pkg::vtx_t  b,
    input  tpc_pkg::dist_t da,
    input  tpc_pkg::dist_t db,
    output tpc_pkg::vtx_t  e
);
    import tpc_pkg::*;

    localparam int MUL_W = DIFF_W + FRAC_W + 1;

    logic [DEN_W-1:0]         rem_reg  [FRAC_W+1];
    logic [DEN_W-1:0]         den_reg  [FRAC_W+1];
    logic [FRAC_W-1:0]        t_reg    [FRAC_W+1];
    vtx_t                     a_reg    [FRAC_W+1];
    logic signed [DIFF_W-1:0] diff_reg [FRAC_W+1][3];
    logic signed [MUL_W-1:0]  prod_reg [3];
    vtx_t                     ap_reg;
    vtx_t                     e_reg;

    // entry stage: divisor is positive since d(a) >= 0 > d(b)
    always_ff @(posedge clk)
    begin
        rem_reg[0]     <= DEN_W'(da);
        den_reg[0]     <= DEN_W'(da) - DEN_W'(db);
        t_reg[0]       <= '0;
        a_reg[0]       <= a;
        diff_reg[0][0] <= DIFF_W'(b.x) - DIFF_W'(a.x);
        diff_reg[0][1] <= DIFF_W'(b.y) - DIFF_W'(a.y);
        diff_reg[0][2] <= DIFF_W'(b.z) - DIFF_W'(a.z);
    end

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < FRAC_W; i++)
    begin : g_div
        logic [DEN_W:0] rem2;
        logic [DEN_W:0] sub;
        logic           ge;

        always_comb
        begin
            rem2 = {rem_reg[i], 1'b0};
            sub  = rem2 - {1'b0, den_reg[i]};
            ge   = (rem2 >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= ge ? sub[DEN_W-1:0] : rem2[DEN_W-1:0];
            den_reg[i+1]  <= den_reg[i];
            t_reg[i+1]    <= {t_reg[i][FRAC_W-2:0], ge};
            a_reg[i+1]    <= a_reg[i];
            diff_reg[i+1] <= diff_reg[i];
        end
    end

    // interpolate: floor((b-a)*t / 2^16) added to a
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= MUL_W'(diff_reg[FRAC_W][k])
                         * MUL_W'($signed({1'b0, t_reg[FRAC_W]}));
        end
        ap_reg    <= a_reg[FRAC_W];
        e_reg.x   <= ap_reg.x + COORD_W'(prod_reg[0] >>> FRAC_W);
        e_reg.y   <= ap_reg.y + COORD_W'(prod_reg[1] >>> FRAC_W);
        e_reg.z   <= ap_reg.z + COORD_W'(prod_reg[2] >>> FRAC_W);
    end

    assign e = e_reg;

endmodule

/* sim/tb_triangle_plane_clipper.sv */
// Self-checking testbench for triangle_plane_clipper: random and directed triangles.
`timescale 1ns / 100ps

module tb_triangle_plane_clipper;
    import tpc_pkg::*;

    localparam int LATENCY   = 22;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 500;

    typedef logic signed [80:0] wide_t;

    // Expected-triangle store and checker
    class clip_scoreboard;
        result_t tri_q[$];
        int      n_err;
        int      n_tri;
        int      n_empty;

        function void note_triangle(result_t r);
            tri_q.push_back(r);
        endfunction

        function void check_triangle(result_t got);
            result_t want;
            if (tri_q.size() == 0)
            begin
                $display("%0t: unexpected triangle word %h", $realtime, got);
                n_err++;
                return;
            end
            want = tri_q.pop_front();
            n_tri++;
            if (got !== want)
            begin
                $display("%0t: triangle mismatch expected %h actual %h",
                         $realtime, want, got);
                n_err++;
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    result_t result;
    logic    result_valid;

    clip_scoreboard sb;
    int      cycles = 0;

    // Local copy of the plane registers
    logic signed [COORD_W-1:0] pt_m [3];
    logic signed [NORM_W-1:0]  nrm_m [3];

    triangle_plane_clipper u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .result      (result),
        .result_valid(result_valid)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("triangle_plane_clipper regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_triangle(result);
    end

    function automatic wide_t signed_dist(vtx_t p);
        wide_t s;
        s = 0;
        s += (wide_t'(p.x) - wide_t'(pt_m[0])) * wide_t'(nrm_m[0]);
        s += (wide_t'(p.y) - wide_t'(pt_m[1])) * wide_t'(nrm_m[1]);
        s += (wide_t'(p.z) - wide_t'(pt_m[2])) * wide_t'(nrm_m[2]);
        return s;
    endfunction

    function automatic vtx_t cut_edge(vtx_t a, vtx_t b, wide_t da, wide_t db);
        wide_t den, rem, diff, step;
        logic [15:0] t;
        logic signed [COORD_W-1:0] ca [3];
        logic signed [COORD_W-1:0] cb [3];
        logic signed [COORD_W-1:0] cr [3];
        den = da - db;
        rem = da;
        t = '0;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem <<< 1;
            t = t << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                t[0] = 1'b1;
            end
        end
        ca = '{a.x, a.y, a.z};
        cb = '{b.x, b.y, b.z};
        for (int k = 0; k < 3; k++)
        begin
            diff = wide_t'(cb[k]) - wide_t'(ca[k]);
            step = (diff * $signed({1'b0, t})) >>> 16;
            cr[k] = COORD_W'(wide_t'(ca[k]) + step);
        end
        return '{x: cr[0], y: cr[1], z: cr[2]};
    endfunction

    function automatic result_t make_tri(vtx_t p0, vtx_t p1, vtx_t p2,
                                         logic lst, logic [1:0] tot);
        result_t r;
        r.out_v0_x = p0.x; r.out_v0_y = p0.y; r.out_v0_z = p0.z;
        r.out_v1_x = p1.x; r.out_v1_y = p1.y; r.out_v1_z = p1.z;
        r.out_v2_x = p2.x; r.out_v2_y = p2.y; r.out_v2_z = p2.z;
        r.last_tri = lst;
        r.tri_total = tot;
        return r;
    endfunction

    // Work out the clipped triangles of one accepted word
    function automatic void predict_clip(item_t it);
        vtx_t  v [3];
        wide_t d [3];
        int    ins [$];
        int    outs [$];
        vtx_t  e0, e1;
        v[0] = '{it.v0_x, it.v0_y, it.v0_z};
        v[1] = '{it.v1_x, it.v1_y, it.v1_z};
        v[2] = '{it.v2_x, it.v2_y, it.v2_z};
        for (int i = 0; i < 3; i++)
        begin
            d[i] = signed_dist(v[i]);
            if (d[i] >= 0) ins.push_back(i);
            else outs.push_back(i);
        end
        case (ins.size())
            0: sb.n_empty++;
            3: sb.note_triangle(make_tri(v[0], v[1], v[2], 1'b1, 2'd1));
            1:
            begin
                e0 = cut_edge(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
                e1 = cut_edge(v[ins[0]], v[outs[1]], d[ins[0]], d[outs[1]]);
                sb.note_triangle(make_tri(v[ins[0]], e0, e1, 1'b1, 2'd1));
            end
            default:
            begin
                e0 = cut_edge(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
                e1 = cut_edge(v[ins[1]], v[outs[0]], d[ins[1]], d[outs[0]]);
                sb.note_triangle(make_tri(v[ins[0]], v[ins[1]], e0, 1'b0, 2'd2));
                sb.note_triangle(make_tri(v[ins[1]], e0, e1, 1'b1, 2'd2));
            end
        endcase
    endfunction

    // One register write; the caller drops the write enable afterwards
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx <= REG_PT_Z) pt_m[idx] = val;
        else nrm_m[idx - REG_N_X] = val[NORM_W-1:0];
    endtask

    task automatic set_plane(vtx_t p, norm_t n);
        write_reg(REG_PT_X, p.x);
        write_reg(REG_PT_Y, p.y);
        write_reg(REG_PT_Z, p.z);
        write_reg(REG_N_X, CFG_W'(n.x));
        write_reg(REG_N_Y, CFG_W'(n.y));
        write_reg(REG_N_Z, CFG_W'(n.z));
        cfg_we <= 1'b0;
    endtask

    // Present one word and hold it until taken; start stays high afterwards
    task automatic send_triangle(item_t it);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_clip(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.tri_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    function automatic item_t rnd_triangle();
        item_t it;
        int    mode;
        mode = $urandom_range(0, 9);
        mode = mode < 3 ? 0 : (mode < 9 ? 1 : 2);
        it = {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode), rnd_coord(mode), rnd_coord(mode)};
        return it;
    endfunction

    function automatic norm_t rnd_normal();
        norm_t n;
        n = {norm_c_t'($urandom), norm_c_t'($urandom), norm_c_t'($urandom)};
        return n;
    endfunction

    function automatic item_t mk(coord_t a, coord_t b, coord_t c, coord_t d,
                                 coord_t e, coord_t f, coord_t g, coord_t h,
                                 coord_t i);
        return {a, b, c, d, e, f, g, h, i};
    endfunction

    // Send a stream in bursts with random gaps
    task automatic burst_stream(int count);
        int left;
        int gap;
        left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                left = $urandom_range(1, 20);
            end
            send_triangle(rnd_triangle());
            left--;
        end
    endtask

    localparam coord_t ONE = 32'sh0001_0000;
    localparam coord_t MAXC = 32'sh7fff_ffff;
    localparam coord_t MINC = 32'sh8000_0000;

    initial
    begin
        sb = new();
        pt_m = '{0, 0, 0};
        nrm_m = '{0, 0, NORM_Z_RST};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset plane z = 0: directed in/out patterns
        send_triangle(mk(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));      // all inside
        send_triangle(mk(0, 0, -ONE, ONE, 0, -ONE, 0, ONE, -ONE));   // none inside
        send_triangle(mk(0, 0, ONE, ONE, 0, -ONE, 0, ONE, -ONE));    // one inside
        send_triangle(mk(0, 0, -ONE, ONE, 0, ONE, 0, ONE, -ONE));    // one inside, middle
        send_triangle(mk(0, 0, ONE, ONE, 0, ONE, 0, ONE, -ONE));     // two inside
        send_triangle(mk(0, 0, -ONE, ONE, 0, ONE, 0, ONE, ONE));     // two inside, first out
        send_triangle(mk(0, 0, 0, ONE, 0, 0, 0, ONE, -ONE));         // on the plane
        send_triangle(mk(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC));
        send_triangle(mk(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC));
        send_triangle(mk(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, 0, -1));
        send_triangle(mk(-1, -1, -1, -1, -1, 0, -1, -1, 1));
        drain();

        // Zero normal: every vertex is inside
        set_plane('{ONE, -ONE, MAXC}, '{0, 0, 0});
        send_triangle(mk(MINC, MINC, MINC, 0, 0, 0, MAXC, MAXC, MAXC));
        drain();

        // Extreme normal and point
        set_plane('{MINC, MAXC, MINC}, '{18'sh1ffff, 18'sh20000, 18'sh1ffff});
        send_triangle(mk(MAXC, MINC, MAXC, MINC, MAXC, MINC, 0, 0, 0));
        send_triangle(mk(MINC, MAXC, MINC, MAXC, MINC, MAXC, 0, 0, 0));
        send_triangle(mk(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, 0, MINC));
        drain();
        set_plane('{MAXC, MINC, MAXC}, '{18'sh20000, 18'sh1ffff, 18'sh20000});
        send_triangle(mk(MAXC, MINC, MAXC, MINC, MAXC, MINC, 0, 0, 0));
        send_triangle(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, MAXC, 0));
        drain();

        // Random phases, each with its own plane
        for (int ph = 0; ph < 10; ph++)
        begin
            vtx_t p;
            if (ph < 7)
                p = '{rnd_coord(1), rnd_coord(1), rnd_coord(1)};
            else
                p = '{rnd_coord(0), rnd_coord(0), rnd_coord(0)};
            set_plane(p, rnd_normal());
            burst_stream(N_RANDOM / 10);
            drain();
        end

        $display("covered %0d triangles checked, %0d fully clipped inputs,",
                 sb.n_tri, sb.n_empty);
        $display("directed extremes plus 10 random planes with bursty input");
        if (sb.n_err == 0 && sb.tri_q.size() == 0)
            $display("triangle_plane_clipper regression: pass");
        else
            $display("triangle_plane_clipper regression: fail");
        $finish;
    end
endmodule
